// ===== design/rk4_driven_oscillator_step_core_defines.svh =====
// Assertion helpers shared by the oscillator step core.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef RK4_DRIVEN_OSCILLATOR_STEP_CORE_DEFINES_SVH
`define RK4_DRIVEN_OSCILLATOR_STEP_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_SAME(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed: lbl");
`define ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed: lbl");
`else
`define ASSERT_SAME(lbl, a, b)
`define ASSERT_NEXT(lbl, a, b)
`endif
`endif

// ===== design/rk4o_pkg.sv =====
package rk4o_pkg;

    // Fixed point format of position, velocity and coefficients.
    localparam int FRAC_BITS = 24;
    localparam int DATA_W    = 32;
    localparam int TIME_W    = 40;
    localparam int SUM_W     = 36;
    localparam int DIV_W     = 40;
    localparam int DIV_STEPS = DIV_W / 8;

    // Offset that makes the weighted sum positive before the divide by six.
    localparam logic [DIV_W-1:0] DIV_OFFSET = 40'd51539607552;
    localparam logic [DIV_W:0]   DIV_BIAS   = 41'd8589934592;

    // Configuration register indexes.
    localparam logic [2:0] CFG_AMPLITUDE = 3'd0;
    localparam logic [2:0] CFG_STIFFNESS = 3'd1;
    localparam logic [2:0] CFG_DAMPING   = 3'd2;
    localparam logic [2:0] CFG_STEP_SIZE = 3'd3;
    localparam logic [2:0] CFG_PHASE_STEP = 3'd4;
    localparam logic [2:0] CFG_INIT_POS  = 3'd5;
    localparam logic [2:0] CFG_INIT_VEL  = 3'd6;

    // Register reset values.
    localparam logic [31:0] RST_AMPLITUDE  = 32'd3355443;
    localparam logic [31:0] RST_STIFFNESS  = 32'd41943040;
    localparam logic [31:0] RST_DAMPING    = 32'd1677722;
    localparam logic [30:0] RST_STEP_SIZE  = 31'd167772;
    localparam logic [31:0] RST_PHASE_STEP = 32'd6835653;
    localparam logic [31:0] RST_INIT_POS   = 32'd16777216;
    localparam logic [31:0] RST_INIT_VEL   = 32'd0;

    // Multiplier operand selection.
    localparam logic [2:0] MS_AMP_COS = 3'd0;
    localparam logic [2:0] MS_STF_Y   = 3'd1;
    localparam logic [2:0] MS_DMP_Z   = 3'd2;
    localparam logic [2:0] MS_Z_H     = 3'd3;
    localparam logic [2:0] MS_ACC_H   = 3'd4;

    // Acceleration accumulator operations.
    localparam logic [1:0] ACC_HOLD = 2'd0;
    localparam logic [1:0] ACC_LOAD = 2'd1;
    localparam logic [1:0] ACC_SUB  = 2'd2;

    typedef struct packed {
        logic       load;
        logic [1:0] cos_stage;
        logic [2:0] mul_sel;
        logic [1:0] acc_op;
        logic       k_cap;
        logic       stage_end;
        logic [1:0] end_stage;
        logic       div_init;
        logic       div_step;
        logic       commit;
    } rk4o_cmd_t;

endpackage

// ===== design/rk4_driven_oscillator_step_core.sv =====
// Advances a cosine-driven damped oscillator by one fourth-order Runge-Kutta step
// per accepted item, in signed Q8.24 with saturation; restart reloads the initial
// position and velocity and clears time and drive phase first. One item is in
// flight at a time. Each item passes a cosine prefetch state, the products on the
// single shared 32x32 multiplier (five for each of the four derivative
// evaluations), a state that closes the last stage, the byte-serial divide by six
// of the weighted sums (an init state and the divide steps), a commit state, and
// the idle state in which the next item is accepted. A finished result waits in
// the output register; the next item may be accepted while it waits, but its
// result is held back until the previous one is taken, and the sequencer stays
// in its commit state for as long as that wait lasts.
// Configuration registers are written through cfg_we, cfg_index and cfg_data while
// the block is idle; the user is bound to this, the block does not enforce it.
`include "rk4_driven_oscillator_step_core_defines.svh"
module rk4_driven_oscillator_step_core import rk4o_pkg::*; #(
    parameter int COS_TABLE_BITS = 10
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     restart,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] position,
    output logic signed [DATA_W-1:0] velocity,
    output logic [TIME_W-1:0]        elapsed_time,
    input  logic                     cfg_we,
    input  logic [2:0]               cfg_index,
    input  logic [31:0]              cfg_data
);

    rk4o_cmd_t cmd;

    rk4o_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    rk4o_dp #(
        .COS_TABLE_BITS(COS_TABLE_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .restart      (restart),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .position     (position),
        .velocity     (velocity),
        .elapsed_time (elapsed_time)
    );

    // An accepted item keeps the block busy on the next cycle.
    `ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    // A new result is posted only as the sequencer returns to idle.
    `ASSERT_SAME(a_result_at_idle, $rose(out_valid), in_ready)
    // A step result is only committed when the output slot can take it.
    `ASSERT_SAME(a_commit_slot, cmd.commit, !out_valid || out_ready)

endmodule

// ===== design/rk4o_cos_rom.sv =====
module rk4o_cos_rom import rk4o_pkg::*; #(
    parameter int TABLE_BITS = 10
) (
    input  logic                         clk,
    input  logic [TABLE_BITS-1:0]        idx,
    output logic signed [DATA_W-1:0]     data
);

    localparam int N = 1 << TABLE_BITS;

    // Series divisors are replaced by reciprocals rounded up; with numerators
    // below 2^32 and divisors below 512 the scaled product floors exactly.
    localparam int          RCP_SHIFT = 42;
    localparam logic [63:0] RCP_ONE   = 64'd1 << RCP_SHIFT;

    // Reciprocals of 2k(2k-1) for k = 1 to 9 (cosine series).
    localparam logic [63:0] RCP_C [9] = '{
        (RCP_ONE + 64'd1) / 64'd2,     (RCP_ONE + 64'd11) / 64'd12,
        (RCP_ONE + 64'd29) / 64'd30,   (RCP_ONE + 64'd55) / 64'd56,
        (RCP_ONE + 64'd89) / 64'd90,   (RCP_ONE + 64'd131) / 64'd132,
        (RCP_ONE + 64'd181) / 64'd182, (RCP_ONE + 64'd239) / 64'd240,
        (RCP_ONE + 64'd305) / 64'd306
    };

    // Reciprocals of 2k(2k+1) for k = 1 to 9 (sine series).
    localparam logic [63:0] RCP_S [9] = '{
        (RCP_ONE + 64'd5) / 64'd6,     (RCP_ONE + 64'd19) / 64'd20,
        (RCP_ONE + 64'd41) / 64'd42,   (RCP_ONE + 64'd71) / 64'd72,
        (RCP_ONE + 64'd109) / 64'd110, (RCP_ONE + 64'd155) / 64'd156,
        (RCP_ONE + 64'd209) / 64'd210, (RCP_ONE + 64'd271) / 64'd272,
        (RCP_ONE + 64'd341) / 64'd342
    };

    // One table entry: quadrant fold and Taylor series in Q2.30.
    function automatic logic [31:0] cos_entry(input int i, input int tbits);
        logic [63:0] quarter;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] a;
        logic [63:0] x2;
        logic [63:0] c;
        logic [63:0] s;
        logic [63:0] v;
        logic [63:0] e;
        logic [127:0] pc;
        logic [127:0] ps;
        quarter = 64'd1 << (tbits - 2);
        q = (64'(i) >> (tbits - 2)) & 64'd3;
        r = 64'(i) & (quarter - 64'd1);
        a = (64'd6746518852 * r) >> tbits;
        x2 = (a * a) >> 30;
        c = 64'd1 << 30;
        s = 64'd1 << 30;
        for (int k = 9; k >= 1; k--) begin
            pc = 128'((x2 * c) >> 30) * 128'(RCP_C[k-1]);
            ps = 128'((x2 * s) >> 30) * 128'(RCP_S[k-1]);
            c = (64'd1 << 30) - 64'(pc >> RCP_SHIFT);
            s = (64'd1 << 30) - 64'(ps >> RCP_SHIFT);
        end
        s = (a * s) >> 30;
        v = (q == 64'd0 || q == 64'd2) ? c : s;
        e = (v + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
        if (q == 64'd1 || q == 64'd2) begin
            e = -e;
        end
        return e[31:0];
    endfunction

    logic [31:0] rom [N];

    // Table contents fixed at elaboration.
    for (genvar g = 0; g < N; g++) begin : g_rom
        assign rom[g] = cos_entry(g, TABLE_BITS);
    end

    // Registered read.
    always_ff @(posedge clk)
    begin
        data <= signed'(rom[idx]);
    end

endmodule

// ===== design/rk4o_dp.sv =====
module rk4o_dp import rk4o_pkg::*; #(
    parameter int COS_TABLE_BITS = 10
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  rk4o_cmd_t                cmd,
    input  logic                     restart,
    input  logic                     cfg_we,
    input  logic [2:0]               cfg_index,
    input  logic [31:0]              cfg_data,
    output logic signed [DATA_W-1:0] position,
    output logic signed [DATA_W-1:0] velocity,
    output logic [TIME_W-1:0]        elapsed_time
);

    function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] fmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        p = p + (64'sd1 <<< (FRAC_BITS - 1));
        return sat64(p >>> FRAC_BITS);
    endfunction

    function automatic logic signed [31:0] sadd(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        if (s[32] != s[31]) begin
            return s[32] ? 32'sh80000000 : 32'sh7fffffff;
        end
        return s[31:0];
    endfunction

    function automatic logic signed [31:0] ssub(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [32:0] s;
        s = 33'(a) - 33'(b);
        if (s[32] != s[31]) begin
            return s[32] ? 32'sh80000000 : 32'sh7fffffff;
        end
        return s[31:0];
    endfunction

    function automatic logic signed [31:0] sat41(input logic signed [40:0] v);
        if (v > 41'sd2147483647) begin
            return 32'sh7fffffff;
        end
        if (v < -41'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // One radix-256 step of a divide by six; remainder stays below six.
    function automatic logic [10:0] div6_step(input logic [2:0] rem, input logic [7:0] b);
        logic [10:0] rp;
        logic [20:0] prod;
        logic [7:0]  q8;
        logic [10:0] r;
        rp = {rem, b};
        prod = 21'(rp) * 21'd683;
        q8 = prod[19:12];
        r = rp - 11'(q8) * 11'd6;
        return {r[2:0], q8};
    endfunction

    logic signed [31:0] amp_reg, stf_reg, dmp_reg, init_pos_reg, init_vel_reg;
    logic [30:0]        step_reg;
    logic [31:0]        pstep_reg;

    logic signed [31:0] pos_reg, vel_reg;
    logic [TIME_W-1:0]  time_reg;
    logic [31:0]        phase_reg;

    logic signed [31:0] ya_reg, za_reg, acc_reg, mres_reg, k_reg;
    logic signed [SUM_W-1:0] sk_reg, sl_reg;
    logic [DIV_W-1:0]   dk_reg, dl_reg;
    logic [2:0]         rk_reg, rl_reg;

    logic signed [31:0] pos_out_reg, vel_out_reg;
    logic [TIME_W-1:0]  time_out_reg;

    logic signed [31:0] h;
    logic [31:0]        hp;
    logic [31:0]        cos_phase;
    logic signed [31:0] cos_val;
    logic signed [31:0] opa, opb;
    logic [10:0]        stk, stl;
    logic signed [40:0] qk, ql;
    logic signed [31:0] pos_new, vel_new;
    logic signed [SUM_W-1:0] kw, lw;

    assign h  = signed'({1'b0, step_reg});
    assign hp = pstep_reg >> 1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_reg      <= signed'(RST_AMPLITUDE);
            stf_reg      <= signed'(RST_STIFFNESS);
            dmp_reg      <= signed'(RST_DAMPING);
            step_reg     <= RST_STEP_SIZE;
            pstep_reg    <= RST_PHASE_STEP;
            init_pos_reg <= signed'(RST_INIT_POS);
            init_vel_reg <= signed'(RST_INIT_VEL);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_AMPLITUDE:  amp_reg      <= signed'(cfg_data);
                CFG_STIFFNESS:  stf_reg      <= signed'(cfg_data);
                CFG_DAMPING:    dmp_reg      <= signed'(cfg_data);
                CFG_STEP_SIZE:  step_reg     <= cfg_data[30:0];
                CFG_PHASE_STEP: pstep_reg    <= cfg_data;
                CFG_INIT_POS:   init_pos_reg <= signed'(cfg_data);
                CFG_INIT_VEL:   init_vel_reg <= signed'(cfg_data);
                default:        ;
            endcase
        end
    end

    // Drive phase for the cosine lookup of each stage.
    always_comb
    begin
        case (cmd.cos_stage) inside
            2'd0:       cos_phase = phase_reg;
            2'd1, 2'd2: cos_phase = phase_reg + hp;
            default:    cos_phase = phase_reg + hp + hp;
        endcase
    end

    rk4o_cos_rom #(
        .TABLE_BITS(COS_TABLE_BITS)
    ) u_rom (
        .clk  (clk),
        .idx  (cos_phase[31 -: COS_TABLE_BITS]),
        .data (cos_val)
    );

    // Shared multiplier operands.
    always_comb
    begin
        case (cmd.mul_sel)
            MS_AMP_COS: begin opa = amp_reg; opb = cos_val; end
            MS_STF_Y:   begin opa = stf_reg; opb = ya_reg;  end
            MS_DMP_Z:   begin opa = dmp_reg; opb = za_reg;  end
            MS_Z_H:     begin opa = za_reg;  opb = h;       end
            default:    begin opa = acc_reg; opb = h;       end
        endcase
    end

    // Shared multiplier with rounding and saturation.
    always_ff @(posedge clk)
    begin
        mres_reg <= fmul(opa, opb);
    end

    // Weighted stage contributions: middle stages count twice.
    always_comb
    begin
        if (cmd.end_stage == 2'd1 || cmd.end_stage == 2'd2)
        begin
            kw = SUM_W'(k_reg) <<< 1;
            lw = SUM_W'(mres_reg) <<< 1;
        end
        else
        begin
            kw = SUM_W'(k_reg);
            lw = SUM_W'(mres_reg);
        end
    end

    assign stk = div6_step(rk_reg, dk_reg[DIV_W-1 -: 8]);
    assign stl = div6_step(rl_reg, dl_reg[DIV_W-1 -: 8]);
    assign qk  = signed'({1'b0, dk_reg}) - signed'(DIV_BIAS);
    assign ql  = signed'({1'b0, dl_reg}) - signed'(DIV_BIAS);
    assign pos_new = sat41(41'(pos_reg) + qk);
    assign vel_new = sat41(41'(vel_reg) + ql);

    // Stage evaluation state and divider.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ya_reg <= restart ? init_pos_reg : pos_reg;
            za_reg <= restart ? init_vel_reg : vel_reg;
            sk_reg <= '0;
            sl_reg <= '0;
        end
        if (cmd.acc_op == ACC_LOAD)
        begin
            acc_reg <= mres_reg;
        end
        else if (cmd.acc_op == ACC_SUB)
        begin
            acc_reg <= ssub(acc_reg, mres_reg);
        end
        if (cmd.k_cap)
        begin
            k_reg <= mres_reg;
        end
        if (cmd.stage_end)
        begin
            sk_reg <= sk_reg + kw;
            sl_reg <= sl_reg + lw;
            case (cmd.end_stage)
                2'd0, 2'd1:
                begin
                    ya_reg <= sadd(pos_reg, k_reg >>> 1);
                    za_reg <= sadd(vel_reg, mres_reg >>> 1);
                end
                2'd2:
                begin
                    ya_reg <= sadd(pos_reg, k_reg);
                    za_reg <= sadd(vel_reg, mres_reg);
                end
                default: ;
            endcase
        end
        if (cmd.div_init)
        begin
            dk_reg <= DIV_W'(sk_reg) + DIV_W'(3) + DIV_OFFSET;
            dl_reg <= DIV_W'(sl_reg) + DIV_W'(3) + DIV_OFFSET;
            rk_reg <= '0;
            rl_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dk_reg <= {dk_reg[DIV_W-9:0], stk[7:0]};
            dl_reg <= {dl_reg[DIV_W-9:0], stl[7:0]};
            rk_reg <= stk[10:8];
            rl_reg <= stl[10:8];
        end
        if (cmd.commit)
        begin
            pos_out_reg  <= pos_new;
            vel_out_reg  <= vel_new;
            time_out_reg <= time_reg + TIME_W'(step_reg);
        end
    end

    // Oscillator state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 32'sd1 <<< FRAC_BITS;
            vel_reg   <= '0;
            time_reg  <= '0;
            phase_reg <= '0;
        end
        else if (cmd.load && restart)
        begin
            pos_reg   <= init_pos_reg;
            vel_reg   <= init_vel_reg;
            time_reg  <= '0;
            phase_reg <= '0;
        end
        else if (cmd.commit)
        begin
            pos_reg   <= pos_new;
            vel_reg   <= vel_new;
            time_reg  <= time_reg + TIME_W'(step_reg);
            phase_reg <= phase_reg + hp + hp;
        end
    end

    assign position     = pos_out_reg;
    assign velocity     = vel_out_reg;
    assign elapsed_time = time_out_reg;

endmodule

// ===== design/rk4o_ctrl.sv =====
module rk4o_ctrl import rk4o_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output rk4o_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PREP   = 3'd1;
    localparam logic [2:0] ST_RUN    = 3'd2;
    localparam logic [2:0] ST_LAST   = 3'd3;
    localparam logic [2:0] ST_DINIT  = 3'd4;
    localparam logic [2:0] ST_DIV    = 3'd5;
    localparam logic [2:0] ST_COMMIT = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [2:0] j_reg, j_next;
    logic [1:0] s_reg, s_next;
    logic [2:0] d_reg, d_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    // Sequencer: five multiplier slots per stage, then the divide and commit.
    always_comb
    begin
        state_next = state_reg;
        j_next     = j_reg;
        s_next     = s_reg;
        d_next     = d_reg;
        cmd        = '0;
        cmd.mul_sel = MS_AMP_COS;
        cmd.acc_op  = ACC_HOLD;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                j_next     = '0;
                s_next     = '0;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                cmd.cos_stage = (j_reg == 3'd4) ? s_reg + 2'd1 : s_reg;
                cmd.stage_end = (j_reg == 3'd0) && (s_reg != 2'd0);
                cmd.end_stage = s_reg - 2'd1;
                unique case (j_reg)
                    3'd0: cmd.mul_sel = MS_AMP_COS;
                    3'd1:
                    begin
                        cmd.mul_sel = MS_STF_Y;
                        cmd.acc_op  = ACC_LOAD;
                    end
                    3'd2:
                    begin
                        cmd.mul_sel = MS_DMP_Z;
                        cmd.acc_op  = ACC_SUB;
                    end
                    3'd3:
                    begin
                        cmd.mul_sel = MS_Z_H;
                        cmd.acc_op  = ACC_SUB;
                    end
                    default:
                    begin
                        cmd.mul_sel = MS_ACC_H;
                        cmd.k_cap   = 1'b1;
                    end
                endcase
                if (j_reg == 3'd4)
                begin
                    j_next = '0;
                    s_next = s_reg + 2'd1;
                    if (s_reg == 2'd3)
                    begin
                        state_next = ST_LAST;
                    end
                end
                else
                begin
                    j_next = j_reg + 3'd1;
                end
            end
            ST_LAST:
            begin
                cmd.stage_end = 1'b1;
                cmd.end_stage = 2'd3;
                state_next    = ST_DINIT;
            end
            ST_DINIT:
            begin
                cmd.div_init = 1'b1;
                d_next       = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                d_next       = d_reg + 3'd1;
                if (d_reg == 3'(DIV_STEPS - 1))
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                cmd.commit = slot_free;
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output item holding register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            j_reg         <= '0;
            s_reg         <= '0;
            d_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            j_reg         <= j_next;
            s_reg         <= s_next;
            d_reg         <= d_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
